// ===== src/indexed_list_store_top_defines.svh =====
// Assertion macros shared by the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_LIST_STORE_TOP_DEFINES_SVH

// Checked outside reset only.
`define ILS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ILS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/ils_pkg.sv =====
// Shared types and defaults for the indexed list store.
package ils_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned DefWidth = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned IndexW   = 5;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 5;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_GET    = 3'd4,
    KIND_CLEAR  = 3'd5,
    KIND_RESIZE = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_INSERT,
    CMD_ERASE
  } cell_cmd_e;

  typedef struct packed {
    logic ok;
    logic rd_en;
  } res_t;

endpackage

// ===== src/ils_cell.sv =====
// One storage cell of the list: holds one element, shifts from either neighbour.
module ils_cell #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned CW    = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ils_pkg::cell_cmd_e cmd_i,
  input  logic [CW-1:0]      pos_i,
  input  logic [CW-1:0]      cnt_i,
  input  logic [WIDTH-1:0]   val_i,
  input  logic [WIDTH-1:0]   left_i,
  input  logic [WIDTH-1:0]   right_i,
  output logic [WIDTH-1:0]   elem_o
);
  import ils_pkg::*;

  localparam logic [CW:0] MyPos = (CW+1)'(IDX);

  logic [CW:0]      pos_x, cnt_x;
  logic [WIDTH-1:0] elem_d, elem_q;

  assign pos_x = {1'b0, pos_i};
  assign cnt_x = {1'b0, cnt_i};

  always_comb begin
    elem_d = elem_q;
    unique case (cmd_i)
      CMD_WRITE: begin
        if (MyPos == pos_x) elem_d = val_i;
      end
      CMD_INSERT: begin
        if (MyPos == pos_x) elem_d = val_i;
        else if (MyPos > pos_x && MyPos <= cnt_x) elem_d = left_i;
      end
      CMD_ERASE: begin
        if (MyPos >= pos_x && (MyPos + 1'b1) < cnt_x) elem_d = right_i;
      end
      default: elem_d = elem_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) elem_q <= '0;
    else elem_q <= elem_d;
  end

  assign elem_o = elem_q;

endmodule

// ===== src/ils_ctrl.sv =====
// Request decode and fill count register for the indexed list store.
module ils_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [ils_pkg::KindW-1:0]  kind_i,
  input  logic [ils_pkg::IndexW-1:0] index_i,
  output ils_pkg::cell_cmd_e         cmd_o,
  output logic [CW-1:0]              pos_o,
  output logic [CW-1:0]              cnt_o,
  output logic [CW-1:0]              cnt_next_o,
  output ils_pkg::res_t              res_o
);
  import ils_pkg::*;

  localparam int unsigned XW = (CW > IndexW) ? CW : IndexW;
  localparam logic [XW-1:0] DepthX = XW'(DEPTH);

  logic [CW-1:0] cnt_d, cnt_q;
  logic [XW-1:0] idx_x, cnt_x;
  logic          full;
  cell_cmd_e     cmd;

  assign idx_x = XW'(index_i);
  assign cnt_x = XW'(cnt_q);
  assign full  = (cnt_x >= DepthX);

  always_comb begin
    cnt_d        = cnt_q;
    cmd          = CMD_NONE;
    pos_o        = CW'(idx_x);
    res_o        = '0;
    unique case (kind_e'(kind_i))
      KIND_PUSH: begin
        pos_o = cnt_q;
        if (!full) begin
          res_o.ok = 1'b1;
          cmd      = CMD_WRITE;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      KIND_POP: begin
        res_o.ok = 1'b1;
        if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
      end
      KIND_INSERT: begin
        if (idx_x <= cnt_x && !full) begin
          res_o.ok = 1'b1;
          cmd      = CMD_INSERT;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      KIND_ERASE: begin
        if (idx_x < cnt_x) begin
          res_o.ok = 1'b1;
          cmd      = CMD_ERASE;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      KIND_GET: begin
        if (idx_x < cnt_x) begin
          res_o.ok    = 1'b1;
          res_o.rd_en = 1'b1;
        end
      end
      KIND_CLEAR: begin
        res_o.ok = 1'b1;
        cnt_d    = '0;
      end
      KIND_RESIZE: begin
        if (idx_x != cnt_x && idx_x <= DepthX) begin
          res_o.ok = 1'b1;
          cnt_d    = CW'(idx_x);
        end
      end
      default: cnt_d = cnt_q;
    endcase
  end

  assign cmd_o      = fire_i ? cmd : CMD_NONE;
  assign cnt_o      = cnt_q;
  assign cnt_next_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (fire_i) cnt_q <= cnt_d;
  end

endmodule

// ===== src/indexed_list_store_top.sv =====
// Top level of the indexed list store: control, row of cells and result register.
//
//   channel  direction  handshake               fields
//   in       sink       in_valid_i / in_stall_o   kind, index, value
//   out      source     out_valid_o / out_stall_i ok, data, count, empty_res
//
// One beat in, one beat out; the result is registered and appears in the cycle after acceptance.
// A new beat is taken every cycle while in_stall_o is low: all cells shift in parallel in that cycle.
// in_stall_o is high only while a result is held and out_stall_i is high.
// Reset clears every element and the count at once; no clearing pass.
module indexed_list_store_top #(
  parameter int unsigned DEPTH = ils_pkg::DefDepth,
  parameter int unsigned WIDTH = ils_pkg::DefWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ils_pkg::KindW-1:0]  in_kind_i,
  input  logic [ils_pkg::IndexW-1:0] in_index_i,
  input  logic [ils_pkg::ValueW-1:0] in_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_ok_o,
  output logic [ils_pkg::ValueW-1:0] out_data_o,
  output logic [ils_pkg::CountW-1:0] out_count_o,
  output logic                       out_empty_res_o
);
  import ils_pkg::*;
  `include "indexed_list_store_top_defines.svh"

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned RdN  = (DEPTH < 32) ? DEPTH : 32;
  localparam int unsigned RdW  = $clog2(RdN);

  logic             in_fire;
  cell_cmd_e        cmd;
  logic [CW-1:0]    pos, cnt, cnt_next;
  res_t             res;
  logic [WIDTH-1:0] val;
  logic [WIDTH-1:0] elems [DEPTH];
  logic [WIDTH-1:0] rd_elem;
  logic [ValueW-1:0] rd_data;

  logic              valid_d, valid_q;
  logic              ok_q;
  logic [ValueW-1:0] data_q;
  logic [CountW-1:0] count_q;
  logic              empty_q;

  assign in_stall_o = valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  ils_ctrl #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .fire_i    (in_fire),
    .kind_i    (in_kind_i),
    .index_i   (in_index_i),
    .cmd_o     (cmd),
    .pos_o     (pos),
    .cnt_o     (cnt),
    .cnt_next_o(cnt_next),
    .res_o     (res)
  );

  generate
    if (WIDTH <= ValueW) begin : g_val_narrow
      assign val     = in_value_i[WIDTH-1:0];
      assign rd_data = ValueW'(rd_elem);
    end else begin : g_val_wide
      assign val     = WIDTH'(in_value_i);
      assign rd_data = rd_elem[ValueW-1:0];
    end
  endgenerate

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = elems[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = elems[i+1];
    end
    ils_cell #(
      .WIDTH(WIDTH),
      .CW   (CW),
      .IDX  (i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i  (cmd),
      .pos_i  (pos),
      .cnt_i  (cnt),
      .val_i  (val),
      .left_i (left),
      .right_i(right),
      .elem_o (elems[i])
    );
  end

  // Index field reaches at most the first 32 cells.
  assign rd_elem = elems[in_index_i[RdW-1:0]];

  always_comb begin
    valid_d = valid_q;
    if (in_fire) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q    <= res.ok;
      data_q  <= res.rd_en ? rd_data : '0;
      count_q <= CountW'(cnt_next);
      empty_q <= (cnt_next == '0);
    end
  end

  assign out_valid_o     = valid_q;
  assign out_ok_o        = ok_q;
  assign out_data_o      = data_q;
  assign out_count_o     = count_q;
  assign out_empty_res_o = empty_q;

  `ILS_ASSERT(a_cnt_in_range, {1'b0, cnt} <= (CW+1)'(DEPTH), "fill count above depth")
  `ILS_ASSERT(a_fail_keeps_cnt, in_fire && !res.ok |=> cnt == $past(cnt), "failed request moved count")
  `ILS_ASSERT(a_data_only_ok, out_valid_o && out_data_o != '0 |-> out_ok_o, "data on failed beat")
  `ILS_ASSERT(a_count_tracks, out_valid_o |-> out_count_o == CountW'(cnt), "held count off register")
  `ILS_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule
